### src/cpc_pkg.sv
// shared types, constants and the arctangent table for the cell-to-polar block
package cpc_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int INDEX_BITS_DEF    = 10;
  localparam int ATAN_ENTRIES      = 24;

  localparam int ID_W       = 32;
  localparam int RING_LSB   = 0;
  localparam int SECTOR_LSB = 10;
  localparam int LAYER_LSB  = 20;

  localparam int LEN_W      = 24;
  localparam int PITCH_W    = 19;
  localparam int OFFSET_W   = 18;
  localparam int POLAR_W    = 17;
  localparam int AZ_W       = 19;
  localparam int AZ_RAW_W   = 20;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int XY_W       = 36;
  localparam int Z_W        = 27;
  localparam int FRAC_SHIFT = 8;

  localparam logic [AZ_RAW_W-1:0] PI_Q16       = 20'd205887;
  localparam logic [AZ_RAW_W-1:0] TWO_PI_Q16   = 20'd411775;
  localparam logic [AZ_RAW_W-1:0] THREE_PI_Q16 = 20'd617662;
  localparam logic [POLAR_W-1:0]  HALF_PI_Q16  = 17'd102944;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER_RADIUS     = 3'd0,
    REG_RING_PITCH       = 3'd1,
    REG_START_DEPTH      = 3'd2,
    REG_LAYER_THICKNESS  = 3'd3,
    REG_SECTOR_PITCH     = 3'd4,
    REG_ODD_LAYER_OFFSET = 3'd5
  } cfg_reg_t;

  typedef logic signed [Z_W-1:0] angle_t;

  // atan(2^-i) in q.24 radians
  localparam angle_t ATAN_Q24 [ATAN_ENTRIES] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
    27'sd1047214,  27'sd524117,  27'sd262123,  27'sd131069,
    27'sd65536,    27'sd32768,   27'sd16384,   27'sd8192,
    27'sd4096,     27'sd2048,    27'sd1024,    27'sd512,
    27'sd256,      27'sd128,     27'sd64,      27'sd32,
    27'sd16,       27'sd8,       27'sd4,       27'sd2
  };

  typedef struct packed {
    logic [LEN_W-1:0]    inner_radius;
    logic [LEN_W-1:0]    ring_pitch;
    logic [LEN_W-1:0]    start_depth;
    logic [LEN_W-1:0]    layer_thickness;
    logic [PITCH_W-1:0]  sector_pitch;
    logic [OFFSET_W-1:0] odd_layer_offset;
  } geom_cfg_t;

  // results that ride along the rotation chain
  typedef struct packed {
    logic [AZ_RAW_W-1:0] az_raw;
    logic [LEN_W-1:0]    radius;
    logic [LEN_W-1:0]    depth;
    logic                len_sat;
    logic                az_clamp;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cell_t;

endpackage

### src/cpc_front.sv
// index unpacking, geometry products and length / azimuth saturation (three stages)
module cpc_front #(
  parameter int INDEX_BITS = cpc_pkg::INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  cpc_pkg::geom_cfg_t       cfg,
  input  logic                     in_valid,
  input  logic [cpc_pkg::ID_W-1:0] cell_id,
  output logic                     out_valid,
  output cpc_pkg::cell_t           cell_out
);

  localparam int RP_W = INDEX_BITS + 1 + cpc_pkg::LEN_W;
  localparam int RS_W = RP_W + 1;
  localparam int DP_W = INDEX_BITS + 2 + cpc_pkg::LEN_W;
  localparam int DS_W = DP_W + 1;
  localparam int AP_W = INDEX_BITS + cpc_pkg::PITCH_W;
  localparam int AS_W = AP_W + 1;

  logic                  v0, v1;
  logic [INDEX_BITS-1:0] ring0, sector0, layer0;
  logic [RP_W-1:0]       rprod1;
  logic signed [DP_W-1:0] dprod1;
  logic [AP_W-1:0]       sprod1;
  logic                  odd1;

  logic signed [INDEX_BITS:0] lm1;
  logic [RS_W-1:0]       rhalf, rsum;
  logic                  rover;
  logic signed [DS_W-1:0] dsum;
  logic                  dneg, dover;
  logic [AS_W-1:0]       asum;
  logic                  aover;
  logic [cpc_pkg::LEN_W-1:0]    rad, dep;
  logic [cpc_pkg::AZ_RAW_W-1:0] az;
  cpc_pkg::cell_t        cell_next;

  // stage 0: indices
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ring0   <= cell_id[cpc_pkg::RING_LSB +: INDEX_BITS];
      sector0 <= cell_id[cpc_pkg::SECTOR_LSB +: INDEX_BITS];
      layer0  <= cell_id[cpc_pkg::LAYER_LSB +: INDEX_BITS];
    end
  end

  // stage 1: one product per coordinate
  assign lm1 = signed'({1'b0, layer0} - (INDEX_BITS + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rprod1 <= RP_W'({ring0, 1'b1}) * RP_W'(cfg.ring_pitch);
      dprod1 <= DP_W'(lm1) * DP_W'(signed'({1'b0, cfg.layer_thickness}));
      sprod1 <= AP_W'(sector0) * AP_W'(cfg.sector_pitch);
      odd1   <= layer0[0];
    end
  end

  // stage 2: offsets and saturation
  always_comb begin
    rhalf = (RS_W'(rprod1) + RS_W'(1)) >> 1;
    rsum  = rhalf + RS_W'(cfg.inner_radius);
    rover = |rsum[RS_W-1:cpc_pkg::LEN_W];
    rad   = rover ? '1 : rsum[cpc_pkg::LEN_W-1:0];

    dsum  = DS_W'(dprod1) + DS_W'(signed'({1'b0, cfg.start_depth}));
    dneg  = dsum[DS_W-1];
    dover = !dneg && (|dsum[DS_W-2:cpc_pkg::LEN_W]);
    if (dneg) begin
      dep = '0;
    end else if (dover) begin
      dep = '1;
    end else begin
      dep = dsum[cpc_pkg::LEN_W-1:0];
    end

    asum  = AS_W'(sprod1) + (odd1 ? AS_W'(cfg.odd_layer_offset) : '0);
    aover = asum > AS_W'(cpc_pkg::THREE_PI_Q16);
    az    = aover ? cpc_pkg::THREE_PI_Q16 : asum[cpc_pkg::AZ_RAW_W-1:0];

    cell_next.x             = cpc_pkg::XY_W'(signed'({1'b0, dep, 8'h00}));
    cell_next.y             = cpc_pkg::XY_W'(signed'({1'b0, rad, 8'h00}));
    cell_next.z             = '0;
    cell_next.side.az_raw   = az;
    cell_next.side.radius   = rad;
    cell_next.side.depth    = dep;
    cell_next.side.len_sat  = rover || dneg || dover;
    cell_next.side.az_clamp = aover;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

### src/cpc_cell.sv
// one cordic vectoring iteration with a fixed shift, registered
module cpc_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cpc_pkg::cell_t cell_in,
  output logic           out_valid,
  output cpc_pkg::cell_t cell_out
);

  logic signed [cpc_pkg::XY_W-1:0] x, y, xs, ys;
  logic signed [cpc_pkg::Z_W-1:0]  z;
  cpc_pkg::cell_t                  cell_next;

  always_comb begin
    x  = cell_in.x;
    y  = cell_in.y;
    z  = cell_in.z;
    // arithmetic shift floors toward minus infinity
    xs = x >>> SHIFT;
    ys = y >>> SHIFT;
    cell_next = cell_in;
    if (y > 0) begin
      cell_next.x = x + ys;
      cell_next.y = y - xs;
      cell_next.z = z + cpc_pkg::ATAN_Q24[SHIFT];
    end else begin
      cell_next.x = x - ys;
      cell_next.y = y + xs;
      cell_next.z = z - cpc_pkg::ATAN_Q24[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

### src/calorimeter_cell_to_polar_coords_core.sv
// top level: config registers, front stages, cordic cell chain and output register
//
// Turns a packed calorimeter cell identifier into cell-centre radius, layer depth,
// polar angle and azimuth. One transfer is taken every clock while the output is not
// stalled; the pipeline is three front stages for index unpacking, the geometry
// products and saturation, one cordic cell per iteration, and the output register.
// The whole pipeline advances together: it freezes only while the output
// register holds a result that the sink does not take, so s_tready depends on
// m_tready in the same cycle. Configuration writes are registered and should be
// made only while no transfer is in flight. Lengths are unsigned q16.8 mm, angles
// are radians times 65536; flags in m_tuser mark saturated lengths and a clamped
// raw azimuth.
module calorimeter_cell_to_polar_coords_core #(
  parameter int CORDIC_STAGES = cpc_pkg::CORDIC_STAGES_DEF,
  parameter int INDEX_BITS    = cpc_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // cfg_data: register value, low bits used per register
  input  logic                          cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpc_pkg::CFG_W-1:0]     cfg_data,
  // s_tdata: cell_id[31:0]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,
  // m_tdata: polar_angle[16:0], azimuth[35:17], radius[59:36], depth[83:60], zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [87:0]                   m_tdata,
  // m_tuser: length_saturated[0], azimuth_clamped[1]
  output logic [1:0]                    m_tuser
);

  // the arctangent table has 24 entries, more stages add nothing
  localparam int NUM_CELLS = (CORDIC_STAGES < cpc_pkg::ATAN_ENTRIES) ?
                             CORDIC_STAGES : cpc_pkg::ATAN_ENTRIES;
  localparam int Q_W       = cpc_pkg::Z_W - 1 - cpc_pkg::FRAC_SHIFT;

  cpc_pkg::geom_cfg_t cfg;
  logic               adv;

  logic           vld   [NUM_CELLS+1];
  cpc_pkg::cell_t chain [NUM_CELLS+1];

  cpc_pkg::cell_t                  last;
  logic signed [cpc_pkg::Z_W-1:0]  zr;
  logic [Q_W-1:0]                  q;
  logic [cpc_pkg::POLAR_W-1:0]     theta;
  logic [cpc_pkg::AZ_RAW_W-1:0]    az_wrap;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cpc_pkg::cfg_reg_t'(cfg_index))
        cpc_pkg::REG_INNER_RADIUS:     cfg.inner_radius     <= cfg_data;
        cpc_pkg::REG_RING_PITCH:       cfg.ring_pitch       <= cfg_data;
        cpc_pkg::REG_START_DEPTH:      cfg.start_depth      <= cfg_data;
        cpc_pkg::REG_LAYER_THICKNESS:  cfg.layer_thickness  <= cfg_data;
        cpc_pkg::REG_SECTOR_PITCH:
          cfg.sector_pitch     <= cfg_data[cpc_pkg::PITCH_W-1:0];
        cpc_pkg::REG_ODD_LAYER_OFFSET:
          cfg.odd_layer_offset <= cfg_data[cpc_pkg::OFFSET_W-1:0];
        default: ;  // unused indices are ignored
      endcase
    end
  end

  // global advance: the pipe only stalls on a held, untaken result
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  cpc_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .cell_id   (s_tdata),
    .out_valid (vld[0]),
    .cell_out  (chain[0])
  );

  // rotation chain, cell i shifts by i
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cpc_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (vld[i]),
      .cell_in   (chain[i]),
      .out_valid (vld[i+1]),
      .cell_out  (chain[i+1])
    );
  end

  // angle rounding to q.16 with clamp, azimuth wrap into (-pi, pi]
  always_comb begin
    last = chain[NUM_CELLS];
    zr   = last.z + cpc_pkg::Z_W'(128);
    q    = zr[cpc_pkg::Z_W-2:cpc_pkg::FRAC_SHIFT];
    if (last.z[cpc_pkg::Z_W-1]) begin
      theta = '0;
    end else if (q > Q_W'(cpc_pkg::HALF_PI_Q16)) begin
      theta = cpc_pkg::HALF_PI_Q16;
    end else begin
      theta = q[cpc_pkg::POLAR_W-1:0];
    end
    // modular subtract leaves the two's complement value in the low bits
    az_wrap = (last.side.az_raw > cpc_pkg::PI_Q16) ?
              last.side.az_raw - cpc_pkg::TWO_PI_Q16 : last.side.az_raw;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'h0, last.side.depth, last.side.radius,
                  az_wrap[cpc_pkg::AZ_W-1:0], theta};
      m_tuser <= {last.side.az_clamp, last.side.len_sat};
    end
  end

endmodule

### src/cpc_checker.sv
// port-level checks for the cell-to-polar block and their binding
module cpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // input side only backs off while the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

  a_polar: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:0] <= 17'd102944)
    else $error("polar angle above pi/2");

  a_az_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[35:17]) <= 19'sd205887) &&
                 ($signed(m_tdata[35:17]) >= -19'sd205887))
    else $error("azimuth out of range");

  // clamp to 3pi then wrap gives exactly pi
  a_az_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[35:17] == 19'd205887)
    else $error("clamped azimuth not pi");

endmodule

bind calorimeter_cell_to_polar_coords_core cpc_checker u_cpc_checker (.*);

### bench/calorimeter_cell_to_polar_coords_core_tb.sv
// self-checking bench for the calorimeter cell to polar coordinates core
module calorimeter_cell_to_polar_coords_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_N     = cpc_pkg::CORDIC_STAGES_DEF;
  localparam int IDX_W        = cpc_pkg::INDEX_BITS_DEF;
  // front stages, one cordic cell per iteration, output register
  localparam int PIPE_LATENCY = CORDIC_N + 4;
  // long sink stall so the pipeline fills and backs up into the source
  localparam int HOLD_CYCLES  = 300;

  localparam longint LEN_MAX     = 64'hFF_FFFF;
  localparam longint AZ_PI       = 205887;
  localparam longint AZ_TWO_PI   = 411775;
  localparam longint AZ_THREE_PI = 617662;
  localparam longint POLAR_MAX   = 102944;

  // atan(2^-i), radians in q.24
  localparam longint ATAN_STEP_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic [31:0]                     cell_id;
    logic [cpc_pkg::POLAR_W-1:0]     polar;
    logic signed [cpc_pkg::AZ_W-1:0] azimuth;
    logic [cpc_pkg::LEN_W-1:0]       radius;
    logic [cpc_pkg::LEN_W-1:0]       depth;
    logic                            len_sat;
    logic                            az_clamp;
  } cell_coords_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cpc_pkg::CFG_W-1:0]     cfg_data  = '0;
  // s_tdata: cell_id[31:0]
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata   = '0;
  // m_tdata: polar_angle[16:0], azimuth[35:17], radius[59:36], depth[83:60], zero pad
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [87:0]          m_tdata;
  // m_tuser: length_saturated[0], azimuth_clamped[1]
  logic [1:0]           m_tuser;

  // geometry as the core should hold it
  cpc_pkg::geom_cfg_t geom = '0;

  logic [31:0]  pending_cells [$];
  cell_coords_t expected_coords [$];
  cell_coords_t coords_due;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_arm  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int cells_sent      = 0;
  int results_checked = 0;
  int len_sat_seen    = 0;
  int az_clamp_seen   = 0;
  int mismatches      = 0;
  int settings_run    = 1;

  calorimeter_cell_to_polar_coords_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // expected coordinates of one cell under the current geometry
  function automatic cell_coords_t cell_to_polar(input logic [31:0] id);
    longint ring, sector, layer, rad, dep, phi, x, y, z, xs, ys, theta;
    int i;
    cell_coords_t c;
    c.cell_id  = id;
    c.len_sat  = 1'b0;
    c.az_clamp = 1'b0;
    ring   = id[cpc_pkg::RING_LSB +: IDX_W];
    sector = id[cpc_pkg::SECTOR_LSB +: IDX_W];
    layer  = id[cpc_pkg::LAYER_LSB +: IDX_W];

    // centre of the ring: half a pitch rounds half up at the lsb
    rad = longint'(geom.inner_radius) + ((2 * ring + 1) * longint'(geom.ring_pitch) + 1) / 2;
    if (rad > LEN_MAX) begin
      rad = LEN_MAX;
      c.len_sat = 1'b1;
    end

    // layer zero sits one thickness in front of the face and may go negative
    dep = longint'(geom.start_depth) + longint'(geom.layer_thickness) * (layer - 1);
    if (dep < 0) begin
      dep = 0;
      c.len_sat = 1'b1;
    end else if (dep > LEN_MAX) begin
      dep = LEN_MAX;
      c.len_sat = 1'b1;
    end

    // vectoring cordic on the clamped lengths; x along depth, y along radius
    if (rad == 0 && dep == 0) begin
      theta = 0;
    end else begin
      x = dep * 256;
      y = rad * 256;
      z = 0;
      for (i = 0; i < CORDIC_N && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP_Q24[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP_Q24[i];
        end
      end
      if (z < 0) theta = 0;
      else theta = (z + 128) / 256;
      if (theta > POLAR_MAX) theta = POLAR_MAX;
    end

    // azimuth: odd layers get the stagger, clamp at 3pi, then wrap into (-pi, pi]
    phi = sector * longint'(geom.sector_pitch);
    if (layer[0]) phi = phi + longint'(geom.odd_layer_offset);
    if (phi > AZ_THREE_PI) begin
      phi = AZ_THREE_PI;
      c.az_clamp = 1'b1;
    end
    if (phi > AZ_PI) phi = phi - AZ_TWO_PI;

    c.polar   = theta[cpc_pkg::POLAR_W-1:0];
    c.azimuth = phi[cpc_pkg::AZ_W-1:0];
    c.radius  = rad[cpc_pkg::LEN_W-1:0];
    c.depth   = dep[cpc_pkg::LEN_W-1:0];
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch: %s", msg);
  endtask

  // index biased toward its edges
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(4))
      0: return '0;
      1: return IDX_W'(1);
      2: return '1;
      3: return '1 - IDX_W'(1);
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    int k;
    logic [1:0] side;
    for (k = 0; k < count; k++) begin
      side = 2'($urandom);
      pending_cells.push_back({side, pick_index(), pick_index(), pick_index()});
    end
  endtask

  task automatic write_reg(input cpc_pkg::cfg_reg_t idx,
                           input logic [cpc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      cpc_pkg::REG_INNER_RADIUS:     geom.inner_radius     = value;
      cpc_pkg::REG_RING_PITCH:       geom.ring_pitch       = value;
      cpc_pkg::REG_START_DEPTH:      geom.start_depth      = value;
      cpc_pkg::REG_LAYER_THICKNESS:  geom.layer_thickness  = value;
      cpc_pkg::REG_SECTOR_PITCH:     geom.sector_pitch     = value[cpc_pkg::PITCH_W-1:0];
      cpc_pkg::REG_ODD_LAYER_OFFSET: geom.odd_layer_offset = value[cpc_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // pipeline empty: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cells.size() != 0 || s_tvalid || expected_coords.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // new geometry only once the pipeline has gone quiet
  task automatic set_geometry(input logic [23:0] ir, rp, sd, lt,
                              input logic [18:0] sp, input logic [17:0] ofs);
    wait_drained();
    write_reg(cpc_pkg::REG_INNER_RADIUS, ir);
    write_reg(cpc_pkg::REG_RING_PITCH, rp);
    write_reg(cpc_pkg::REG_START_DEPTH, sd);
    write_reg(cpc_pkg::REG_LAYER_THICKNESS, lt);
    write_reg(cpc_pkg::REG_SECTOR_PITCH, cpc_pkg::CFG_W'(sp));
    write_reg(cpc_pkg::REG_ODD_LAYER_OFFSET, cpc_pkg::CFG_W'(ofs));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
    @(negedge clk);
  endtask

  // source side: keep an offered cell steady until its transfer, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_coords.push_back(cell_to_polar(s_tdata));
        cells_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_cells.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long sink stall, counted down on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sink side: check every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_coords.size() == 0) begin
          report_mismatch($sformatf("result with no cell outstanding, tdata %h", m_tdata));
        end else begin
          coords_due = expected_coords.pop_front();
          if (m_tdata[16:0] !== coords_due.polar)
            report_mismatch($sformatf("cell %h polar_angle got %0d expected %0d",
                                      coords_due.cell_id, m_tdata[16:0], coords_due.polar));
          if (m_tdata[35:17] !== coords_due.azimuth)
            report_mismatch($sformatf("cell %h azimuth got %0d expected %0d",
                                      coords_due.cell_id, $signed(m_tdata[35:17]),
                                      coords_due.azimuth));
          if (m_tdata[59:36] !== coords_due.radius)
            report_mismatch($sformatf("cell %h radius got %h expected %h",
                                      coords_due.cell_id, m_tdata[59:36], coords_due.radius));
          if (m_tdata[83:60] !== coords_due.depth)
            report_mismatch($sformatf("cell %h depth got %h expected %h",
                                      coords_due.cell_id, m_tdata[83:60], coords_due.depth));
          if (m_tdata[87:84] !== 4'h0)
            report_mismatch($sformatf("cell %h tdata pad got %h", coords_due.cell_id,
                                      m_tdata[87:84]));
          if (m_tuser[0] !== coords_due.len_sat)
            report_mismatch($sformatf("cell %h length_saturated got %b expected %b",
                                      coords_due.cell_id, m_tuser[0], coords_due.len_sat));
          if (m_tuser[1] !== coords_due.az_clamp)
            report_mismatch($sformatf("cell %h azimuth_clamped got %b expected %b",
                                      coords_due.cell_id, m_tuser[1], coords_due.az_clamp));
          results_checked++;
          if (coords_due.len_sat) len_sat_seen++;
          if (coords_due.az_clamp) az_clamp_seen++;
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry is all zero: both lengths zero, polar angle zero
    send_idle_pct = 37;
    recv_idle_pct = 66;
    pending_cells.push_back(32'h0000_0000);
    pending_cells.push_back(32'hFFFF_FFFF);
    pending_cells.push_back(32'h5555_5555);
    pending_cells.push_back(32'hAAAA_AAAA);
    queue_random(20);

    // detector-like geometry, 48 sectors with a half-sector stagger
    set_geometry(24'd20480, 24'd461, 24'd640000, 24'd1152, 19'd8579, 18'd4289);
    pending_cells.push_back(32'h0000_0000);  // first ring, sector and layer
    pending_cells.push_back(32'h0000_03FF);  // last ring
    pending_cells.push_back(32'h000F_FC00);  // last sector, raw azimuth above 3pi
    pending_cells.push_back(32'h3FF0_0000);  // last layer
    pending_cells.push_back(32'h0010_0000);  // layer one sits on the front face
    pending_cells.push_back(32'h0020_0000);
    pending_cells.push_back(32'h0030_0401);  // odd layer picks up the stagger
    pending_cells.push_back(32'hC000_0000);  // side bits only
    pending_cells.push_back(32'h0000_5C00);  // just below pi
    pending_cells.push_back(32'h0000_6000);  // just above pi, wraps negative
    pending_cells.push_back(32'h0001_2000);  // just above 3pi, clamped
    queue_random(100);

    // every length register at its top, sector pitch 2pi, offset pi: radius overflow, depth overflow past layer one
    set_geometry(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 19'd411775,
                 18'd205887);
    send_idle_pct = 66;
    recv_idle_pct = 37;
    pending_cells.push_back(32'h3FFF_FFFF);
    pending_cells.push_back(32'h0010_0000);
    pending_cells.push_back(32'h0010_0400);
    queue_random(60);

    // front face at zero: layer zero goes negative, layer one has zero depth
    set_geometry(24'd0, 24'd1, 24'd0, 24'd2000, 19'd8579, 18'd4289);
    pending_cells.push_back(32'h0000_0005);
    pending_cells.push_back(32'h0010_0007);
    pending_cells.push_back(32'h0010_0000);
    queue_random(80);

    // random geometry at full rate, with one long sink stall
    set_geometry(24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 4095)),
                 24'($urandom_range(0, 1 << 22)), 24'($urandom_range(0, 1 << 14)),
                 19'($urandom_range(0, 2000)), 18'($urandom_range(0, 205887)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(120);
    hold_arm = 1'b1;

    // zero pitches: fixed lengths, odd layers land exactly on pi
    set_geometry(24'hFF_FF00, 24'd0, 24'hFF_FFFF, 24'd0, 19'd0, 18'd205887);
    queue_random(70);

    wait_drained();
    $display("covered %0d cell transfers over %0d geometry settings, %0d results checked",
             cells_sent, settings_run, results_checked);
    $display("%0d results with a saturated length, %0d with a clamped azimuth, %0d mismatches",
             len_sat_seen, az_clamp_seen, mismatches);
    if (mismatches == 0) begin
      $display("calorimeter_cell_to_polar_coords_core regression: pass");
    end else begin
      $display("calorimeter_cell_to_polar_coords_core regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("calorimeter_cell_to_polar_coords_core regression: fail");
    $finish;
  end

endmodule
